/* hw/rtl/ba_pkg.sv */
// ----------------------------------------------------------------------------
// ba_pkg
// Types and codes shared by the buddy allocator controller and datapath.
// ----------------------------------------------------------------------------
package ba_pkg;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_ZERO     = 3'd1;
    localparam logic [2:0] STAT_NOMEM    = 3'd2;
    localparam logic [2:0] STAT_OUTSIDE  = 3'd3;
    localparam logic [2:0] STAT_NOTALLOC = 3'd4;
    localparam logic [2:0] STAT_NULL     = 3'd5;

    typedef struct packed {
        logic        func;
        logic [31:0] request_size;
        logic [31:0] free_address;
    } ba_in_t;

    typedef struct packed {
        logic [2:0]  result_status;
        logic [31:0] result_address;
    } ba_out_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_INIT, ST_IDLE, ST_DISPATCH,
        ST_A_SIZE, ST_A_SRCH, ST_A_POP, ST_A_POPW, ST_A_MARK,
        ST_A_PH1, ST_A_PH2, ST_A_PLO, ST_A_PL1, ST_A_PL2, ST_A_NEXT,
        ST_F_RD, ST_F_CHK, ST_F_OFF, ST_F_C1, ST_F_C2,
        ST_F_CLR, ST_F_BCHK, ST_F_RMW, ST_F_UP, ST_F_PH1, ST_F_PH2,
        ST_OK, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_INIT, OP_LOAD,
        OP_TGT_DEC, OP_CUR_FROM_TGT, OP_CUR_DEC, OP_CUR_INC,
        OP_POP_RD, OP_RM_RD, OP_RM_WR, OP_PUSH1, OP_PUSH2,
        OP_MARK, OP_MARK_SPLIT, OP_SET_PUSH_LOW,
        OP_MARK_RD, OP_ALIGN, OP_CHILD0_RD, OP_CHILD1_RD, OP_CLR_RD, OP_MERGE,
        OP_FINISH, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] code;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic addr_null;
        logic addr_out;
        logic size_zero;
        logic size_big;
        logic min_big;
        logic size_gt;
        logic head_nil;
        logic cur_zero;
        logic cur_lt_tgt;
        logic cur_last;
        logic mark_q;
        logic off_ok;
        logic out_busy;
        logic clr_last;
    } flags_t;

endpackage

/* hw/rtl/ba_ctrl.sv */
// ----------------------------------------------------------------------------
// ba_ctrl
// Sequencer for allocate and free requests; drives datapath commands.
// ----------------------------------------------------------------------------
module ba_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ba_pkg::flags_t  flags,
    output ba_pkg::cmd_t    cmd
);
    import ba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (flags.clr_last) state_next = ST_INIT;
            ST_INIT:     state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                if (flags.is_free) begin
                    if (flags.addr_null || flags.addr_out) state_next = ST_DONE;
                    else state_next = ST_F_RD;
                end else begin
                    if (flags.size_zero || flags.size_big || flags.min_big) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_A_SIZE;
                    end
                end
            end
            ST_A_SIZE:   if (!flags.size_gt) state_next = ST_A_SRCH;
            ST_A_SRCH: begin
                if (!flags.head_nil) state_next = ST_A_POP;
                else if (flags.cur_zero) state_next = ST_DONE;
            end
            ST_A_POP:    state_next = ST_A_POPW;
            ST_A_POPW:   state_next = ST_A_MARK;
            ST_A_MARK:   state_next = flags.cur_lt_tgt ? ST_A_PH1 : ST_OK;
            ST_A_PH1:    state_next = ST_A_PH2;
            ST_A_PH2:    state_next = ST_A_PLO;
            ST_A_PLO:    state_next = ST_A_PL1;
            ST_A_PL1:    state_next = ST_A_PL2;
            ST_A_PL2:    state_next = ST_A_NEXT;
            ST_A_NEXT:   state_next = ST_A_POP;
            ST_F_RD:     state_next = ST_F_CHK;
            ST_F_CHK: begin
                if (flags.mark_q) state_next = ST_F_OFF;
                else if (flags.cur_zero) state_next = ST_DONE;
                else state_next = ST_F_RD;
            end
            ST_F_OFF: begin
                if (!flags.off_ok) state_next = ST_DONE;
                else if (flags.cur_last) state_next = ST_F_CLR;
                else state_next = ST_F_C1;
            end
            ST_F_C1:     state_next = flags.mark_q ? ST_DONE : ST_F_C2;
            ST_F_C2:     state_next = flags.mark_q ? ST_DONE : ST_F_CLR;
            ST_F_CLR:    state_next = flags.cur_zero ? ST_F_PH1 : ST_F_BCHK;
            ST_F_BCHK:   state_next = flags.mark_q ? ST_F_PH1 : ST_F_RMW;
            ST_F_RMW:    state_next = ST_F_UP;
            ST_F_UP:     state_next = ST_F_CLR;
            ST_F_PH1:    state_next = ST_F_PH2;
            ST_F_PH2:    state_next = ST_OK;
            ST_OK:       state_next = ST_DONE;
            ST_DONE:     if (!flags.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        cmd.code = STAT_OK;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:    cmd.op = OP_CLEAR;
            ST_INIT:     cmd.op = OP_INIT;
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            ST_DISPATCH: begin
                if (flags.is_free) begin
                    if (flags.addr_null) begin
                        cmd.op   = OP_FINISH;
                        cmd.code = STAT_NULL;
                    end else if (flags.addr_out) begin
                        cmd.op   = OP_FINISH;
                        cmd.code = STAT_OUTSIDE;
                    end
                end else begin
                    if (flags.size_zero) begin
                        cmd.op   = OP_FINISH;
                        cmd.code = STAT_ZERO;
                    end else if (flags.size_big || flags.min_big) begin
                        cmd.op   = OP_FINISH;
                        cmd.code = STAT_NOMEM;
                    end
                end
            end
            ST_A_SIZE:   cmd.op = flags.size_gt ? OP_TGT_DEC : OP_CUR_FROM_TGT;
            ST_A_SRCH: begin
                if (flags.head_nil) begin
                    if (flags.cur_zero) begin
                        cmd.op   = OP_FINISH;
                        cmd.code = STAT_NOMEM;
                    end else begin
                        cmd.op = OP_CUR_DEC;
                    end
                end
            end
            ST_A_POP:    cmd.op = OP_POP_RD;
            ST_A_POPW:   cmd.op = OP_RM_WR;
            ST_A_MARK:   cmd.op = flags.cur_lt_tgt ? OP_MARK_SPLIT : OP_MARK;
            ST_A_PH1:    cmd.op = OP_PUSH1;
            ST_A_PH2:    cmd.op = OP_PUSH2;
            ST_A_PLO:    cmd.op = OP_SET_PUSH_LOW;
            ST_A_PL1:    cmd.op = OP_PUSH1;
            ST_A_PL2:    cmd.op = OP_PUSH2;
            ST_A_NEXT:   cmd.op = OP_CUR_INC;
            ST_F_RD:     cmd.op = OP_MARK_RD;
            ST_F_CHK: begin
                if (flags.mark_q) begin
                    cmd.op = OP_ALIGN;
                end else if (flags.cur_zero) begin
                    cmd.op   = OP_FINISH;
                    cmd.code = STAT_NOTALLOC;
                end else begin
                    cmd.op = OP_CUR_DEC;
                end
            end
            ST_F_OFF: begin
                if (!flags.off_ok) begin
                    cmd.op   = OP_FINISH;
                    cmd.code = STAT_NOTALLOC;
                end else if (!flags.cur_last) begin
                    cmd.op = OP_CHILD0_RD;
                end
            end
            ST_F_C1: begin
                if (flags.mark_q) begin
                    cmd.op   = OP_FINISH;
                    cmd.code = STAT_NOTALLOC;
                end else begin
                    cmd.op = OP_CHILD1_RD;
                end
            end
            ST_F_C2: begin
                if (flags.mark_q) begin
                    cmd.op   = OP_FINISH;
                    cmd.code = STAT_NOTALLOC;
                end
            end
            ST_F_CLR:    cmd.op = OP_CLR_RD;
            ST_F_BCHK:   if (!flags.mark_q) cmd.op = OP_RM_RD;
            ST_F_RMW:    cmd.op = OP_RM_WR;
            ST_F_UP:     cmd.op = OP_MERGE;
            ST_F_PH1:    cmd.op = OP_PUSH1;
            ST_F_PH2:    cmd.op = OP_PUSH2;
            ST_OK: begin
                cmd.op   = OP_FINISH;
                cmd.code = STAT_OK;
            end
            ST_DONE:     if (!flags.out_busy) cmd.op = OP_EMIT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

/* hw/rtl/ba_datapath.sv */
// ----------------------------------------------------------------------------
// ba_datapath
// Mark tree memory, free-list link memories, level heads and result register.
// ----------------------------------------------------------------------------
module ba_datapath #(
    parameter int POOL_SIZE_LOG2 = 15,
    parameter int MIN_BLOCK_LOG2 = 5,
    parameter int LEVELS         = 11
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ba_pkg::cmd_t    cmd,
    input  ba_pkg::ba_in_t  s_data,
    input  logic            cfg_valid,
    input  logic [31:0]     cfg_data,
    input  logic            m_ready,
    output logic            m_valid,
    output ba_pkg::ba_out_t m_data,
    output ba_pkg::flags_t  flags
);
    import ba_pkg::*;

    localparam int UNIT_W    = LEVELS - 1;
    localparam int LINK_W    = LEVELS;
    localparam int NODE_W    = LEVELS;
    localparam int NLEAF     = 1 << UNIT_W;
    localparam int NODES     = (1 << LEVELS) - 1;
    localparam int LV_W      = $clog2(LEVELS);
    localparam int LEAF_LOG2 = POOL_SIZE_LOG2 - UNIT_W;
    localparam int SPAN      = POOL_SIZE_LOG2 - MIN_BLOCK_LOG2;
    localparam int TMAX      = (SPAN < 0) ? 0 : ((SPAN < UNIT_W) ? SPAN : UNIT_W);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NLEAF);
    localparam logic [32:0] POOL_BYTES = 33'd1 << POOL_SIZE_LOG2;

    function automatic logic [NODE_W-1:0] node_idx(input logic [LV_W-1:0] lv,
                                                   input logic [UNIT_W-1:0] un);
        logic [NODE_W-1:0] first;
        first = (NODE_W'(1) << lv) - NODE_W'(1);
        return first + NODE_W'(un >> (UNIT_W - int'(lv)));
    endfunction

    logic              mark_mem [NODES];
    logic [LINK_W-1:0] fwd_mem  [NLEAF];
    logic [LINK_W-1:0] bwd_mem  [NLEAF];
    logic [LINK_W-1:0] head_reg [LEVELS];

    logic [31:0]       base_reg;
    logic              func_reg;
    logic [31:0]       size_reg;
    logic [31:0]       addr_reg;
    logic [UNIT_W-1:0] unit_reg, u_reg, rm_u_reg, pu_reg;
    logic [LV_W-1:0]   cur_reg, tgt_reg, pl_reg;
    logic [2:0]        status_reg;
    logic              m_valid_reg;
    ba_out_t           m_data_reg;
    logic [NODE_W-1:0] clr_cnt_reg;
    logic              mark_q_reg;
    logic [LINK_W-1:0] fwd_q_reg, bwd_q_reg;

    logic [LV_W-1:0]   head_idx;
    logic [LINK_W-1:0] head_rd;
    logic [UNIT_W-1:0] size_u, half_c, unit_msk;
    logic [31:0]       off;
    logic [32:0]       base_end, blk;
    int                shc;

    logic              mk_we, mk_wd, mk_re;
    logic [NODE_W-1:0] mk_wa, mk_ra;
    logic              fw_we, bw_we, lk_re;
    logic [UNIT_W-1:0] fw_wa, bw_wa, lk_ra;
    logic [LINK_W-1:0] fw_wd, bw_wd;

    always_comb begin
        head_idx = (cmd.op == OP_PUSH1 || cmd.op == OP_PUSH2) ? pl_reg : cur_reg;
        head_rd  = head_reg[head_idx];
        shc      = UNIT_W - int'(cur_reg);
        size_u   = UNIT_W'(1) << shc;
        half_c   = UNIT_W'(1) << (shc - 1);
        unit_msk = unit_reg & ~(size_u - UNIT_W'(1));
        if (cur_reg == '0) unit_msk = '0;
        off      = addr_reg - base_reg;
        base_end = {1'b0, base_reg} + POOL_BYTES - 33'd1;
        blk      = 33'd1 << (POOL_SIZE_LOG2 - int'(tgt_reg));
    end

    always_comb begin
        flags.is_free    = (func_reg == FUNC_FREE);
        flags.addr_null  = (addr_reg == 32'd0);
        flags.addr_out   = (addr_reg < base_reg) || ({1'b0, addr_reg} > base_end);
        flags.size_zero  = (size_reg == 32'd0);
        flags.size_big   = ({1'b0, size_reg} > POOL_BYTES);
        flags.min_big    = (MIN_BLOCK_LOG2 > POOL_SIZE_LOG2);
        flags.size_gt    = ({1'b0, size_reg} > blk);
        flags.head_nil   = (head_reg[cur_reg] == NIL);
        flags.cur_zero   = (cur_reg == '0);
        flags.cur_lt_tgt = (cur_reg < tgt_reg);
        flags.cur_last   = (cur_reg == LV_W'(UNIT_W));
        flags.mark_q     = mark_q_reg;
        flags.off_ok     = (off == (32'(unit_reg) << LEAF_LOG2));
        flags.out_busy   = m_valid_reg && !m_ready;
        flags.clr_last   = (clr_cnt_reg == NODE_W'(NODES - 1));
    end

    always_comb begin
        mk_we = 1'b0;
        mk_wd = 1'b0;
        mk_wa = '0;
        mk_re = 1'b0;
        mk_ra = '0;
        fw_we = 1'b0;
        fw_wa = '0;
        fw_wd = '0;
        bw_we = 1'b0;
        bw_wa = '0;
        bw_wd = '0;
        lk_re = 1'b0;
        lk_ra = '0;
        case (cmd.op)
            OP_CLEAR: begin
                mk_we = 1'b1;
                mk_wa = clr_cnt_reg;
            end
            OP_INIT: begin
                fw_we = 1'b1;
                fw_wd = NIL;
                bw_we = 1'b1;
                bw_wd = NIL;
            end
            OP_POP_RD: begin
                lk_re = 1'b1;
                lk_ra = head_rd[UNIT_W-1:0];
            end
            OP_RM_RD: begin
                lk_re = 1'b1;
                lk_ra = rm_u_reg;
            end
            OP_RM_WR: begin
                fw_we = (bwd_q_reg != NIL);
                fw_wa = bwd_q_reg[UNIT_W-1:0];
                fw_wd = fwd_q_reg;
                bw_we = (fwd_q_reg != NIL);
                bw_wa = fwd_q_reg[UNIT_W-1:0];
                bw_wd = bwd_q_reg;
            end
            OP_PUSH1: begin
                fw_we = 1'b1;
                fw_wa = pu_reg;
                fw_wd = head_rd;
                bw_we = 1'b1;
                bw_wa = pu_reg;
                bw_wd = NIL;
            end
            OP_PUSH2: begin
                bw_we = (head_rd != NIL);
                bw_wa = head_rd[UNIT_W-1:0];
                bw_wd = LINK_W'(pu_reg);
            end
            OP_MARK, OP_MARK_SPLIT: begin
                mk_we = 1'b1;
                mk_wd = 1'b1;
                mk_wa = node_idx(cur_reg, u_reg);
            end
            OP_MARK_RD: begin
                mk_re = 1'b1;
                mk_ra = node_idx(cur_reg, unit_msk);
            end
            OP_CHILD0_RD: begin
                mk_re = 1'b1;
                mk_ra = node_idx(cur_reg + LV_W'(1), unit_reg);
            end
            OP_CHILD1_RD: begin
                mk_re = 1'b1;
                mk_ra = node_idx(cur_reg + LV_W'(1), unit_reg + half_c);
            end
            OP_CLR_RD: begin
                mk_we = 1'b1;
                mk_wa = node_idx(cur_reg, unit_reg);
                mk_re = 1'b1;
                mk_ra = node_idx(cur_reg, unit_reg ^ size_u);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mk_we) mark_mem[mk_wa] <= mk_wd;
        if (mk_re) mark_q_reg <= mark_mem[mk_ra];
    end

    always_ff @(posedge aclk) begin
        if (fw_we) fwd_mem[fw_wa] <= fw_wd;
        if (bw_we) bwd_mem[bw_wa] <= bw_wd;
        if (lk_re) begin
            fwd_q_reg <= fwd_mem[lk_ra];
            bwd_q_reg <= bwd_mem[lk_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= 32'd0;
            m_valid_reg <= 1'b0;
            clr_cnt_reg <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= (i == 0) ? '0 : NIL;
            end
        end else begin
            if (cfg_valid) base_reg <= cfg_data;
            if (cmd.op == OP_EMIT) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (cmd.op)
                OP_CLEAR: clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
                OP_RM_WR: if (bwd_q_reg == NIL) head_reg[cur_reg] <= fwd_q_reg;
                OP_PUSH2: head_reg[pl_reg] <= LINK_W'(pu_reg);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                func_reg <= s_data.func;
                size_reg <= s_data.request_size;
                addr_reg <= s_data.free_address;
                tgt_reg  <= LV_W'(TMAX);
                cur_reg  <= LV_W'(UNIT_W);
                unit_reg <= UNIT_W'((s_data.free_address - base_reg) >> LEAF_LOG2);
            end
            OP_TGT_DEC:       tgt_reg <= tgt_reg - LV_W'(1);
            OP_CUR_FROM_TGT:  cur_reg <= tgt_reg;
            OP_CUR_DEC:       cur_reg <= cur_reg - LV_W'(1);
            OP_CUR_INC:       cur_reg <= cur_reg + LV_W'(1);
            OP_POP_RD:        u_reg   <= head_rd[UNIT_W-1:0];
            OP_MARK_SPLIT: begin
                pl_reg <= cur_reg + LV_W'(1);
                pu_reg <= u_reg + half_c;
            end
            OP_SET_PUSH_LOW:  pu_reg   <= u_reg;
            OP_ALIGN:         unit_reg <= unit_msk;
            OP_CLR_RD: begin
                rm_u_reg <= unit_reg ^ size_u;
                pl_reg   <= cur_reg;
                pu_reg   <= unit_reg;
            end
            OP_MERGE: begin
                unit_reg <= unit_reg & ~size_u;
                cur_reg  <= cur_reg - LV_W'(1);
            end
            OP_FINISH:        status_reg <= cmd.code;
            OP_EMIT: begin
                m_data_reg.result_status <= status_reg;
                if (status_reg == STAT_OK && func_reg == FUNC_ALLOC) begin
                    m_data_reg.result_address <= base_reg + (32'(u_reg) << LEAF_LOG2);
                end else begin
                    m_data_reg.result_address <= 32'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hw/rtl/buddy_allocator_core.sv */
// ----------------------------------------------------------------------------
// buddy_allocator_core
// Binary buddy allocator for one pool of 2^POOL_SIZE_LOG2 bytes.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ valid/ready channel: func 0 allocates request_size
// bytes, func 1 frees free_address. Each request yields one result on the m_
// channel with a status code and, for a successful allocate, the address.
// The user must write pool_base through the cfg_ channel only while no
// request is in flight; the block itself does not enforce this. One request
// is handled at a time. An allocate finds the target level for request_size,
// searches the free lists from that level up toward level 0 (the whole pool)
// and splits the block found down to the target level. A free walks up from
// the finest level to the marked node, checks its offset and children and
// merges it with free buddies; rejected requests end early. Most steps access
// the mark tree memory or the link memories. After reset the mark tree is
// cleared one node per cycle, followed by a step that seeds the root free
// list; s_ready stays low until then. A finished result waits in the output
// register while the receiver stalls; the next request is accepted meanwhile
// and completes only once the register is free.
// ----------------------------------------------------------------------------
module buddy_allocator_core #(
    parameter int POOL_SIZE_LOG2 = 15,
    parameter int MIN_BLOCK_LOG2 = 5,
    parameter int LEVELS         = 11
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ba_pkg::ba_in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ba_pkg::ba_out_t m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [31:0]     cfg_data
);
    import ba_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    assign cfg_ready = 1'b1;

    ba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    ba_datapath #(
        .POOL_SIZE_LOG2 (POOL_SIZE_LOG2),
        .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2),
        .LEVELS         (LEVELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .flags     (flags)
    );

    a_reset_blocks: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request accepted right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in flight");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.result_status <= STAT_NULL)
        else $error("result status out of range");

    a_fail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_status != STAT_OK |-> m_data.result_address == 32'd0)
        else $error("failed request returned an address");

endmodule
